// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the pose transform RTL.
// Has no dependencies; each macro takes its clock and reset from the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define EQPT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define EQPT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== hdl/eqpt_pkg.sv =====
// Shared constants, types and rounding helper for the Euler pose transform.
// No dependencies; used by eqpt_trig and the top level by scoped names.
package eqpt_pkg;

   localparam int ANG_W   = 17;
   localparam int COORD_W = 32;
   localparam int TRIG_W  = 32;
   localparam int MAT_W   = 34;

   // Angle codes are read in units of 1/512 degree for the half angle.
   localparam logic [16:0] HALF_TURN    = 17'd92160;
   localparam logic [16:0] QUARTER_TURN = 17'd46080;

   // pi * 2^46 / 92160, rounded: degrees-code to Q30 radians.
   localparam logic [31:0] RAD_K   = 32'd2398762259;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   localparam int SIN_STEPS = 5;
   localparam int COS_STEPS = 6;

   localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [7:0] COS_DIV [COS_STEPS] =
      '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

   // floor(2^32 / d): the quotient estimate is low by at most one.
   localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
      32'(64'h1_0000_0000 / 110), 32'(64'h1_0000_0000 / 72),
      32'(64'h1_0000_0000 / 42),  32'(64'h1_0000_0000 / 20),
      32'(64'h1_0000_0000 / 6)};
   localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
      32'(64'h1_0000_0000 / 132), 32'(64'h1_0000_0000 / 90),
      32'(64'h1_0000_0000 / 56),  32'(64'h1_0000_0000 / 30),
      32'(64'h1_0000_0000 / 12),  32'(64'h1_0000_0000 / 2)};

   // Register stages of the trig unit, of the quaternion and matrix work, and in all.
   localparam int TRIG_LAT  = 24;
   localparam int XFORM_LAT = 9;
   localparam int PIPE_LAT  = TRIG_LAT + XFORM_LAT;

   // Values that travel beside the Horner chains.
   typedef struct packed {
      logic [31:0] x2;
      logic [30:0] x;
      logic        neg;
      logic        flip;
   } side_type;

   // Point and offset carried down the pipeline.
   typedef struct packed {
      logic signed [COORD_W-1:0] rx;
      logic signed [COORD_W-1:0] ry;
      logic signed [COORD_W-1:0] rz;
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [COORD_W-1:0] oz;
   } point_type;

   // Round a Q30-scaled sum to nearest, ties toward plus infinity.
   function automatic logic signed [37:0] rnd30(input logic signed [67:0] v);
      logic signed [67:0] s;
      s = (v + 68'sd536870912) >>> 30;
      return s[37:0];
   endfunction

endpackage

// ===== hdl/eqpt_trig.sv =====
// Pipelined half-angle sine and cosine of one Q8.8 degree angle, Q30 results.
// Depends on eqpt_pkg for constants, divisor tables and side_type.
module eqpt_trig (
   input  logic                                  clock,
   input  logic signed [eqpt_pkg::ANG_W-1:0]    angle,
   output logic signed [eqpt_pkg::TRIG_W-1:0]   sin_q,
   output logic signed [eqpt_pkg::TRIG_W-1:0]   cos_q
);

   localparam int SIDE_N = 3 * eqpt_pkg::COS_STEPS + 1;

   logic [16:0] mag_in;
   logic [15:0] m_in;
   logic [15:0] m_ff;
   logic [47:0] mk_ff;
   logic [30:0] x_ff;
   logic [30:0] x4_ff;
   logic [61:0] xsq_ff;
   logic [1:0]  nf1_ff, nf2_ff, nf3_ff, nf4_ff;

   eqpt_pkg::side_type side_ff [SIDE_N];

   logic [30:0] sin_t [eqpt_pkg::SIN_STEPS];
   logic [30:0] cos_t [eqpt_pkg::COS_STEPS];

   logic [61:0] sp_ff;
   logic [30:0] smag_ff, smag2_ff;

   // Magnitude of the angle, folded into the first quarter turn.
   always_comb begin
      mag_in = angle[16] ? 17'(-angle) : 17'(angle);
      if (mag_in > eqpt_pkg::QUARTER_TURN) begin
         m_in = 16'(eqpt_pkg::HALF_TURN - mag_in);
      end else begin
         m_in = 16'(mag_in);
      end
   end

   // Front stages: fold, scale to radians, square.
   always_ff @(posedge clock) begin
      m_ff   <= m_in;
      nf1_ff <= {angle[16], (mag_in > eqpt_pkg::QUARTER_TURN)};
      mk_ff  <= 48'(m_ff) * 48'(eqpt_pkg::RAD_K);
      nf2_ff <= nf1_ff;
      x_ff   <= 31'((mk_ff + 48'd32768) >> 16);
      nf3_ff <= nf2_ff;
      xsq_ff <= 62'(x_ff) * 62'(x_ff);
      x4_ff  <= x_ff;
      nf4_ff <= nf3_ff;
      side_ff[0].x2   <= 32'((xsq_ff + 62'h2000_0000) >> 30);
      side_ff[0].x    <= x4_ff;
      side_ff[0].neg  <= nf4_ff[1];
      side_ff[0].flip <= nf4_ff[0];
   end

   // Side values follow the Horner steps one stage at a time.
   for (genvar k = 1; k < SIDE_N; k++) begin : g_side
      always_ff @(posedge clock) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // Cosine series: each step is multiply, reciprocal multiply, correct.
   for (genvar j = 0; j < eqpt_pkg::COS_STEPS; j++) begin : g_cos
      logic [30:0] t_in;
      logic [31:0] p_ff, p2_ff;
      logic [63:0] qr_ff;
      logic [31:0] q0, q;
      logic [39:0] rem;

      if (j == 0) begin : g_first
         assign t_in = eqpt_pkg::Q30_ONE;
      end else begin : g_next
         assign t_in = cos_t[j-1];
      end

      always_comb begin
         q0  = qr_ff[63:32];
         rem = 40'(p2_ff) - 40'(q0) * 40'(eqpt_pkg::COS_DIV[j]);
         q   = (rem >= 40'(eqpt_pkg::COS_DIV[j])) ? q0 + 32'd1 : q0;
      end

      always_ff @(posedge clock) begin
         p_ff     <= 32'((64'(side_ff[3*j].x2) * 64'(t_in)) >> 30);
         qr_ff    <= 64'(p_ff) * 64'(eqpt_pkg::COS_RECIP[j]);
         p2_ff    <= p_ff;
         cos_t[j] <= (q >= 32'(eqpt_pkg::Q30_ONE)) ? 31'd0
                     : 31'(32'(eqpt_pkg::Q30_ONE) - q);
      end
   end

   // Sine series, same step structure with its own divisors.
   for (genvar j = 0; j < eqpt_pkg::SIN_STEPS; j++) begin : g_sin
      logic [30:0] t_in;
      logic [31:0] p_ff, p2_ff;
      logic [63:0] qr_ff;
      logic [31:0] q0, q;
      logic [39:0] rem;

      if (j == 0) begin : g_first
         assign t_in = eqpt_pkg::Q30_ONE;
      end else begin : g_next
         assign t_in = sin_t[j-1];
      end

      always_comb begin
         q0  = qr_ff[63:32];
         rem = 40'(p2_ff) - 40'(q0) * 40'(eqpt_pkg::SIN_DIV[j]);
         q   = (rem >= 40'(eqpt_pkg::SIN_DIV[j])) ? q0 + 32'd1 : q0;
      end

      always_ff @(posedge clock) begin
         p_ff     <= 32'((64'(side_ff[3*j].x2) * 64'(t_in)) >> 30);
         qr_ff    <= 64'(p_ff) * 64'(eqpt_pkg::SIN_RECIP[j]);
         p2_ff    <= p_ff;
         sin_t[j] <= (q >= 32'(eqpt_pkg::Q30_ONE)) ? 31'd0
                     : 31'(32'(eqpt_pkg::Q30_ONE) - q);
      end
   end

   // Sine = x times the series with the angle's sign; cosine takes the fold's sign.
   always_ff @(posedge clock) begin
      sp_ff    <= 62'(side_ff[3*eqpt_pkg::SIN_STEPS].x)
                  * 62'(sin_t[eqpt_pkg::SIN_STEPS-1]);
      smag_ff  <= 31'(sp_ff >> 30);
      smag2_ff <= smag_ff;
      sin_q    <= side_ff[SIDE_N-1].neg ? -32'(smag2_ff) : 32'(smag2_ff);
      cos_q    <= side_ff[SIDE_N-1].flip ? -32'(cos_t[eqpt_pkg::COS_STEPS-1])
                  : 32'(cos_t[eqpt_pkg::COS_STEPS-1]);
   end

endmodule

// ===== hdl/euler_quaternion_point_transform.sv =====
// Euler ZYX pose transform of one point: quaternion build, rotation, offset.
// Depends on eqpt_pkg, eqpt_trig and assert_macros.svh.
//
//   channel   ports                          handshake
//   request   req_* angles, point, offset     start high, busy low
//   response  rsp_world_x/y/z                 rsp_valid strobe, one cycle
//
// Each beat passes the trig units (Horner series, the cosine of six steps,
// three stages each), then the quaternion products, matrix and rotation.
// One beat is taken every cycle while busy is low; busy is high during
// reset and in the cycle after it. Reset clears the valid bits only.
// The receiver cannot stall, so no stage ever holds.
`include "assert_macros.svh"

module euler_quaternion_point_transform (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [eqpt_pkg::ANG_W-1:0]    req_roll_angle,
   input  logic signed [eqpt_pkg::ANG_W-1:0]    req_pitch_angle,
   input  logic signed [eqpt_pkg::ANG_W-1:0]    req_yaw_angle,
   input  logic signed [eqpt_pkg::COORD_W-1:0]  req_ref_x,
   input  logic signed [eqpt_pkg::COORD_W-1:0]  req_ref_y,
   input  logic signed [eqpt_pkg::COORD_W-1:0]  req_ref_z,
   input  logic signed [eqpt_pkg::COORD_W-1:0]  req_offset_x,
   input  logic signed [eqpt_pkg::COORD_W-1:0]  req_offset_y,
   input  logic signed [eqpt_pkg::COORD_W-1:0]  req_offset_z,
   output logic                                  rsp_valid,
   output logic signed [eqpt_pkg::COORD_W-1:0]  rsp_world_x,
   output logic signed [eqpt_pkg::COORD_W-1:0]  rsp_world_y,
   output logic signed [eqpt_pkg::COORD_W-1:0]  rsp_world_z
);

   localparam int LAT = eqpt_pkg::PIPE_LAT;

   logic busy_ff;
   logic [LAT-1:0] vld_ff;
   eqpt_pkg::point_type pt_ff [LAT-1];

   logic signed [31:0] sr, cr, sp, cp, sy, cy;
   logic signed [31:0] cr25_ff, sr25_ff, cr26_ff, sr26_ff;
   logic signed [63:0] cycp_ff, sysp_ff, cysp_ff, sycp_ff;
   logic signed [31:0] aw_ff, ax_ff, ay_ff, az_ff;
   logic signed [63:0] awcr_ff, axsr_ff, awsr_ff, axcr_ff;
   logic signed [63:0] aycr_ff, azsr_ff, azcr_ff, aysr_ff;
   logic signed [31:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [63:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [eqpt_pkg::MAT_W-1:0] mat_ff [3][3];
   logic signed [65:0] mv_ff [3][3];
   logic signed [37:0] rot_ff [3];
   logic signed [38:0] sum_w [3];
   logic signed [31:0] sat_w [3];
   logic signed [eqpt_pkg::MAT_W-1:0] one_m;
   logic cos_in_rng;

   assign one_m = eqpt_pkg::MAT_W'(signed'({1'b0, eqpt_pkg::Q30_ONE}));

   // Busy is the registered reset: high during reset and in the cycle after it.
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy = busy_ff;

   // Valid bits travel with each beat; only they are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start && !busy_ff};
      end
   end
   assign rsp_valid = vld_ff[LAT-1];

   // Point and offset delay line beside the arithmetic.
   always_ff @(posedge clock) begin
      pt_ff[0] <= '{rx: req_ref_x, ry: req_ref_y, rz: req_ref_z,
                    ox: req_offset_x, oy: req_offset_y, oz: req_offset_z};
   end
   for (genvar k = 1; k < LAT - 1; k++) begin : g_pt
      always_ff @(posedge clock) begin
         pt_ff[k] <= pt_ff[k-1];
      end
   end

   // One trig unit per axis.
   eqpt_trig u_roll  (.clock(clock), .angle(req_roll_angle),  .sin_q(sr), .cos_q(cr));
   eqpt_trig u_pitch (.clock(clock), .angle(req_pitch_angle), .sin_q(sp), .cos_q(cp));
   eqpt_trig u_yaw   (.clock(clock), .angle(req_yaw_angle),   .sin_q(sy), .cos_q(cy));

   // Yaw times pitch: each component is a single product.
   always_ff @(posedge clock) begin
      cycp_ff <= cy * cp;
      sysp_ff <= sy * sp;
      cysp_ff <= cy * sp;
      sycp_ff <= sy * cp;
      cr25_ff <= cr;
      sr25_ff <= sr;
      aw_ff   <= 32'(eqpt_pkg::rnd30(68'(cycp_ff)));
      ax_ff   <= 32'(eqpt_pkg::rnd30(-68'(sysp_ff)));
      ay_ff   <= 32'(eqpt_pkg::rnd30(68'(cysp_ff)));
      az_ff   <= 32'(eqpt_pkg::rnd30(68'(sycp_ff)));
      cr26_ff <= cr25_ff;
      sr26_ff <= sr25_ff;
   end

   // Then times roll.
   always_ff @(posedge clock) begin
      awcr_ff <= aw_ff * cr26_ff;
      axsr_ff <= ax_ff * sr26_ff;
      awsr_ff <= aw_ff * sr26_ff;
      axcr_ff <= ax_ff * cr26_ff;
      aycr_ff <= ay_ff * cr26_ff;
      azsr_ff <= az_ff * sr26_ff;
      azcr_ff <= az_ff * cr26_ff;
      aysr_ff <= ay_ff * sr26_ff;
      qw_ff   <= 32'(eqpt_pkg::rnd30(68'(awcr_ff) - 68'(axsr_ff)));
      qx_ff   <= 32'(eqpt_pkg::rnd30(68'(awsr_ff) + 68'(axcr_ff)));
      qy_ff   <= 32'(eqpt_pkg::rnd30(68'(aycr_ff) + 68'(azsr_ff)));
      qz_ff   <= 32'(eqpt_pkg::rnd30(68'(azcr_ff) - 68'(aysr_ff)));
   end

   // Narrow a rounded Q30 value to the matrix width.
   function automatic logic signed [eqpt_pkg::MAT_W-1:0] MAT_W_CAST(
      input logic signed [37:0] v);
      return v[eqpt_pkg::MAT_W-1:0];
   endfunction

   // Rotation matrix of the composed quaternion.
   always_ff @(posedge clock) begin
      xx_ff <= qx_ff * qx_ff;
      yy_ff <= qy_ff * qy_ff;
      zz_ff <= qz_ff * qz_ff;
      xy_ff <= qx_ff * qy_ff;
      xz_ff <= qx_ff * qz_ff;
      yz_ff <= qy_ff * qz_ff;
      wx_ff <= qw_ff * qx_ff;
      wy_ff <= qw_ff * qy_ff;
      wz_ff <= qw_ff * qz_ff;
      mat_ff[0][0] <= one_m - MAT_W_CAST(eqpt_pkg::rnd30((68'(yy_ff) + 68'(zz_ff)) <<< 1));
      mat_ff[0][1] <= MAT_W_CAST(eqpt_pkg::rnd30((68'(xy_ff) - 68'(wz_ff)) <<< 1));
      mat_ff[0][2] <= MAT_W_CAST(eqpt_pkg::rnd30((68'(xz_ff) + 68'(wy_ff)) <<< 1));
      mat_ff[1][0] <= MAT_W_CAST(eqpt_pkg::rnd30((68'(xy_ff) + 68'(wz_ff)) <<< 1));
      mat_ff[1][1] <= one_m - MAT_W_CAST(eqpt_pkg::rnd30((68'(xx_ff) + 68'(zz_ff)) <<< 1));
      mat_ff[1][2] <= MAT_W_CAST(eqpt_pkg::rnd30((68'(yz_ff) - 68'(wx_ff)) <<< 1));
      mat_ff[2][0] <= MAT_W_CAST(eqpt_pkg::rnd30((68'(xz_ff) - 68'(wy_ff)) <<< 1));
      mat_ff[2][1] <= MAT_W_CAST(eqpt_pkg::rnd30((68'(yz_ff) + 68'(wx_ff)) <<< 1));
      mat_ff[2][2] <= one_m - MAT_W_CAST(eqpt_pkg::rnd30((68'(xx_ff) + 68'(yy_ff)) <<< 1));
   end

   // Matrix times point, one product per entry.
   for (genvar i = 0; i < 3; i++) begin : g_row
      always_ff @(posedge clock) begin
         mv_ff[i][0] <= mat_ff[i][0] * pt_ff[LAT-4].rx;
         mv_ff[i][1] <= mat_ff[i][1] * pt_ff[LAT-4].ry;
         mv_ff[i][2] <= mat_ff[i][2] * pt_ff[LAT-4].rz;
         rot_ff[i]   <= eqpt_pkg::rnd30(68'(mv_ff[i][0]) + 68'(mv_ff[i][1])
                                        + 68'(mv_ff[i][2]));
      end
   end

   // Add the offset and saturate to the coordinate range.
   always_comb begin
      sum_w[0] = 39'(rot_ff[0]) + 39'(pt_ff[LAT-2].ox);
      sum_w[1] = 39'(rot_ff[1]) + 39'(pt_ff[LAT-2].oy);
      sum_w[2] = 39'(rot_ff[2]) + 39'(pt_ff[LAT-2].oz);
      for (int i = 0; i < 3; i++) begin
         if (sum_w[i] > 39'sh0_7FFF_FFFF) begin
            sat_w[i] = 32'sh7FFF_FFFF;
         end else if (sum_w[i] < -39'sh0_8000_0000) begin
            sat_w[i] = 32'sh8000_0000;
         end else begin
            sat_w[i] = sum_w[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_world_x <= sat_w[0];
      rsp_world_y <= sat_w[1];
      rsp_world_z <= sat_w[2];
   end

   // High when all three trig cosines lie within plus or minus one.
   assign cos_in_rng = (cr <= 32'sh4000_0000) && (cr >= -32'sh4000_0000)
                       && (cp <= 32'sh4000_0000) && (cp >= -32'sh4000_0000)
                       && (cy <= 32'sh4000_0000) && (cy >= -32'sh4000_0000);

   // A response beat always traces back to an earlier accepted request beat.
   `EQPT_ASSERT_IMP(a_rsp_src, clock, reset, rsp_valid, $past(start && !busy, LAT))
   // Busy goes low through its register once reset is gone.
   `EQPT_ASSERT_NXT(a_busy_clr, clock, 1'b0, !reset, !busy)
   // Series cosines of a valid beat never leave the unit range.
   `EQPT_ASSERT_IMP(a_cos_rng, clock, reset, vld_ff[eqpt_pkg::TRIG_LAT-1], cos_in_rng)

endmodule
